// File: hw/rtl/rmq_pkg.sv
// ----------------------------------------------------------------------------
// rmq_pkg
// Shared constants and types for the ring message queue.
// ----------------------------------------------------------------------------
`default_nettype none

package rmq_pkg;

    localparam int DEPTH    = 16;
    localparam int MSG_BITS = 64;
    localparam int NCELLS   = DEPTH - 1;

    typedef logic [MSG_BITS-1:0] msg_t;

    typedef enum logic [1:0] {
        CMD_ENQ  = 2'd0,
        CMD_DEQ  = 2'd1,
        CMD_PEEK = 2'd2,
        CMD_OVW  = 2'd3
    } cmd_t;

    typedef struct packed {
        logic enq;
        logic deq;
        logic ovw;
        msg_t msg;
    } cell_ctrl_t;

endpackage

`default_nettype wire

// File: hw/rtl/rmq_cell.sv
// ----------------------------------------------------------------------------
// rmq_cell
// One queue slot: a message word and an occupancy bit. Shifts to the head on
// dequeue, takes a new item as first free cell, overwrite as last used cell.
// ----------------------------------------------------------------------------
`default_nettype none

module rmq_cell (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire rmq_pkg::cell_ctrl_t ctrl,
    input  wire logic                prev_valid,
    input  wire logic                next_valid,
    input  wire rmq_pkg::msg_t       next_data,
    output logic                     valid,
    output rmq_pkg::msg_t            data
);

    logic          valid_reg;
    logic          valid_next;
    rmq_pkg::msg_t data_reg;
    rmq_pkg::msg_t data_next;

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (ctrl.deq)
        begin
            valid_next = next_valid;
            data_next  = next_data;
        end
        else if (ctrl.enq && !valid_reg && prev_valid)
        begin
            valid_next = 1'b1;
            data_next  = ctrl.msg;
        end
        else if (ctrl.ovw && valid_reg && !next_valid)
        begin
            data_next  = ctrl.msg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign valid = valid_reg;
    assign data  = data_reg;

endmodule

`default_nettype wire

// File: hw/rtl/ring_message_queue_top.sv
// ----------------------------------------------------------------------------
// ring_message_queue_top
// Message queue with enqueue, dequeue, peek and overwrite-newest.
// ----------------------------------------------------------------------------
// One item per clock: busy stays low, and the result of an item accepted at
// one edge is shown on ok/msg_out with done high for the following cycle
// only. The receiver cannot stall, so it must take every result as it comes.
// Storage is a row of DEPTH-1 cells with the oldest message in cell 0;
// dequeue shifts the whole row by one cell in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ring_message_queue_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  command,
    input  wire logic [63:0] msg_in,
    output logic             done,
    output logic             ok,
    output logic [63:0]      msg_out
);

    logic                 cell_valid [rmq_pkg::NCELLS];
    rmq_pkg::msg_t        cell_data  [rmq_pkg::NCELLS];
    rmq_pkg::cell_ctrl_t  ctrl;
    rmq_pkg::cmd_t        cmd;
    logic                 accept;
    logic                 empty;
    logic                 full;
    logic                 ok_next;
    logic [63:0]          msg_out_next;

    logic                 done_reg;
    logic                 ok_reg;
    logic [63:0]          msg_out_reg;

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign cmd    = rmq_pkg::cmd_t'(command);
    assign empty  = !cell_valid[0];
    assign full   = cell_valid[rmq_pkg::NCELLS-1];

    always_comb
    begin
        ctrl.enq     = 1'b0;
        ctrl.deq     = 1'b0;
        ctrl.ovw     = 1'b0;
        ctrl.msg     = msg_in[rmq_pkg::MSG_BITS-1:0];
        ok_next      = 1'b0;
        msg_out_next = '0;
        case (cmd)
            rmq_pkg::CMD_ENQ:
            begin
                ok_next  = !full;
                ctrl.enq = accept && !full;
            end
            rmq_pkg::CMD_DEQ:
            begin
                ok_next  = !empty;
                ctrl.deq = accept && !empty;
                if (!empty)
                begin
                    msg_out_next = 64'(cell_data[0]);
                end
            end
            rmq_pkg::CMD_PEEK:
            begin
                ok_next = !empty;
                if (!empty)
                begin
                    msg_out_next = 64'(cell_data[0]);
                end
            end
            rmq_pkg::CMD_OVW:
            begin
                ok_next  = !empty;
                ctrl.ovw = accept && !empty;
            end
            default:
            begin
                ok_next = 1'b0;
            end
        endcase
    end

    for (genvar i = 0; i < rmq_pkg::NCELLS; i++)
    begin : g_cell
        logic          prev_valid;
        logic          next_valid;
        rmq_pkg::msg_t next_data;

        if (i == 0)
        begin : g_first
            assign prev_valid = 1'b1;
        end
        else
        begin : g_mid
            assign prev_valid = cell_valid[i-1];
        end

        if (i == rmq_pkg::NCELLS-1)
        begin : g_last
            assign next_valid = 1'b0;
            assign next_data  = '0;
        end
        else
        begin : g_link
            assign next_valid = cell_valid[i+1];
            assign next_data  = cell_data[i+1];
        end

        rmq_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .prev_valid (prev_valid),
            .next_valid (next_valid),
            .next_data  (next_data),
            .valid      (cell_valid[i]),
            .data       (cell_data[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ok_reg      <= ok_next;
            msg_out_reg <= msg_out_next;
        end
    end

    assign done    = done_reg;
    assign ok      = ok_reg;
    assign msg_out = msg_out_reg;

endmodule

`default_nettype wire
